### src/esrc_pkg.sv
`timescale 1ns / 1ps

package esrc_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);
  localparam int unsigned DIV_W  = 32;

  localparam logic [2:0] REG_TEMP     = 3'd0;
  localparam logic [2:0] REG_PRES_LOW = 3'd1;
  localparam logic [2:0] REG_PRES_HI  = 3'd2;
  localparam logic [2:0] REG_PRES_P9  = 3'd3;
  localparam logic [2:0] REG_HUM      = 3'd4;

  localparam logic [31:0] HUM_MAX = 32'd419430400;

  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } esrc_cal_t;

  typedef struct packed {
    logic [31:0] x1;
    logic [31:0] d;
    logic [15:0] rh;
    logic [31:0] pbase;
  } esrc_item_t;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           full;
    logic           empty;
  } esrc_qstat_t;

  typedef struct packed {
    logic [15:0] t;
    logic [16:0] h;
    logic        dz;
    logic        dbl;
  } esrc_side_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

endpackage

### src/esrc_front.sv
`timescale 1ns / 1ps

module esrc_front import esrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] raw_temperature,
  input  logic [19:0] raw_pressure,
  input  logic [15:0] raw_humidity,
  input  esrc_cal_t   cal,
  input  esrc_qstat_t qs,
  output logic        push,
  output esrc_item_t  item
);

  logic fv;

  assign in_ready = !fv || !qs.full;
  assign push     = fv && !qs.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.x1    <= ({12'd0, raw_temperature} >> 3) - (cal.t1 << 1);
      item.d     <= ({12'd0, raw_temperature} >> 4) - cal.t1;
      item.rh    <= raw_humidity;
      item.pbase <= 32'd1048576 - {12'd0, raw_pressure};
    end
  end

endmodule

### src/esrc_fifo.sv
`timescale 1ns / 1ps

module esrc_fifo import esrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  esrc_item_t  wdata,
  input  logic        pop,
  output esrc_item_t  rdata,
  output esrc_qstat_t qs
);

  esrc_item_t     mem [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QCW-1:0] count;

  assign rdata    = mem[rp];
  assign qs.count = count;
  assign qs.full  = (count == QCW'(QDEPTH));
  assign qs.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == QAW'(QDEPTH - 1)) ? '0 : wp + QAW'(1);
      end
      if (pop) begin
        rp <= (rp == QAW'(QDEPTH - 1)) ? '0 : rp + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

### src/esrc_div.sv
`timescale 1ns / 1ps

module esrc_div import esrc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  input  esrc_side_t       in_side,
  output logic             out_v,
  output logic [DIV_W-1:0] quotient,
  output esrc_side_t       out_side
);

  logic [DIV_W-1:0] rem  [DIV_W];
  logic [DIV_W-1:0] num  [DIV_W];
  logic [DIV_W-1:0] dsr  [DIV_W];
  esrc_side_t       side [DIV_W];
  logic [DIV_W-1:0] vld;

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic [DIV_W-1:0] rem_i, num_i, dsr_i;
    esrc_side_t       side_i;
    logic             v_i;
    logic [DIV_W:0]   trial, diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign num_i  = dividend;
      assign dsr_i  = divisor;
      assign side_i = in_side;
      assign v_i    = in_v;
    end else begin : g_rest
      assign rem_i  = rem[k-1];
      assign num_i  = num[k-1];
      assign dsr_i  = dsr[k-1];
      assign side_i = side[k-1];
      assign v_i    = vld[k-1];
    end

    assign trial = {rem_i, num_i[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_i};
    assign ge    = (trial >= {1'b0, dsr_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        num[k]  <= {num_i[DIV_W-2:0], ge};
        dsr[k]  <= dsr_i;
        side[k] <= side_i;
      end
    end
  end

  assign out_v    = vld[DIV_W-1];
  assign quotient = num[DIV_W-1];
  assign out_side = side[DIV_W-1];

endmodule

### src/esrc_back.sv
`timescale 1ns / 1ps

module esrc_back import esrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  esrc_cal_t   cal,
  input  esrc_qstat_t qs,
  input  esrc_item_t  qitem,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] temperature_centi,
  output logic [16:0] humidity_q10,
  output logic [19:0] pressure_pa,
  output logic        pressure_divisor_zero
);

  logic        en;
  logic [12:1] v;

  logic [31:0] s1_mv1, s1_mdd, s1_pb;
  logic [15:0] s1_rh;
  logic [31:0] s2_v1, s2_m2, s2_pb;
  logic [15:0] s2_rh;
  logic [31:0] s3_tf, s3_pb;
  logic [15:0] s3_rh;
  logic [31:0] s4_h0, s4_pv1, s4_pb;
  logic [15:0] s4_rh, s4_t;
  logic [31:0] s5_mh5, s5_mh6, s5_mh3, s5_mq, s5_mp5, s5_mp2, s5_pb;
  logic [15:0] s5_rh, s5_t;
  logic [31:0] s6_a, s6_b1, s6_m6, s6_m3, s6_mp5, s6_mp2, s6_pb;
  logic [15:0] s6_t;
  logic [31:0] s7_bm, s7_a, s7_v2, s7_v1b, s7_pb;
  logic [15:0] s7_t;
  logic [31:0] s8_b, s8_a, s8_pm, s8_pn;
  logic [15:0] s8_t;
  logic [31:0] s9_hh, s9_den, s9_pnum;
  logic [15:0] s9_t;
  logic [31:0] s10_hq2, s10_hh, s10_den, s10_dvd;
  logic [15:0] s10_t;
  logic        s10_dz, s10_dbl;
  logic [31:0] s11_hm, s11_hh, s11_den, s11_dvd;
  logic [15:0] s11_t;
  logic        s11_dz, s11_dbl;
  logic [31:0] s12_den, s12_dvd;
  esrc_side_t  s12_side;

  logic        dq_v;
  logic [31:0] dq_q;
  esrc_side_t  dq_side;

  logic        r1_v, r2_v, r3_v;
  logic [31:0] r1_p, r2_p, r3_p, r2_mpp, r2_mp8, r3_mt, r3_v2t;
  esrc_side_t  r1_side, r2_side, r3_side;

  logic [31:0] tv, hq, hf, trim;
  logic [15:0] tsat;
  logic [16:0] hsat;
  logic [33:0] pf;

  assign en  = !out_valid || out_ready;
  assign pop = en && !qs.empty;

  always_comb begin
    tv = asr(s3_tf * 32'd5 + 32'd128, 8);
    if ($signed(tv) < -32'sd32768) begin
      tsat = 16'h8000;
    end else if ($signed(tv) > 32'sd32767) begin
      tsat = 16'h7fff;
    end else begin
      tsat = tv[15:0];
    end
    hq = asr(s9_hh, 15);
    hf = s11_hh - asr(s11_hm, 4);
    if (hf[31]) begin
      hsat = '0;
    end else if (hf > HUM_MAX) begin
      hsat = HUM_MAX[28:12];
    end else begin
      hsat = hf[28:12];
    end
    trim = asr(asr(r3_mt, 12) + r3_v2t + cal.p7, 4);
    pf   = {2'b00, r3_p} + {{2{trim[31]}}, trim};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      r1_v      <= 1'b0;
      r2_v      <= 1'b0;
      r3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[11:1], pop};
      r1_v      <= dq_v;
      r2_v      <= r1_v;
      r3_v      <= r2_v;
      out_valid <= r3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mv1 <= qitem.x1 * cal.t2;
      s1_mdd <= qitem.d * qitem.d;
      s1_rh  <= qitem.rh;
      s1_pb  <= qitem.pbase;

      s2_v1 <= asr(s1_mv1, 11);
      s2_m2 <= asr(s1_mdd, 12) * cal.t3;
      s2_rh <= s1_rh;
      s2_pb <= s1_pb;

      s3_tf <= s2_v1 + asr(s2_m2, 14);
      s3_rh <= s2_rh;
      s3_pb <= s2_pb;

      s4_t   <= tsat;
      s4_h0  <= s3_tf - 32'd76800;
      s4_pv1 <= asr(s3_tf, 1) - 32'd64000;
      s4_rh  <= s3_rh;
      s4_pb  <= s3_pb;

      s5_mh5 <= cal.h5 * s4_h0;
      s5_mh6 <= s4_h0 * cal.h6;
      s5_mh3 <= s4_h0 * cal.h3;
      s5_mq  <= asr(s4_pv1, 2) * asr(s4_pv1, 2);
      s5_mp5 <= s4_pv1 * cal.p5;
      s5_mp2 <= cal.p2 * s4_pv1;
      s5_rh  <= s4_rh;
      s5_t   <= s4_t;
      s5_pb  <= s4_pb;

      s6_a   <= asr(({16'd0, s5_rh} << 14) - (cal.h4 << 20) - s5_mh5 + 32'd16384, 15);
      s6_b1  <= asr(s5_mh6, 10) * (asr(s5_mh3, 11) + 32'd32768);
      s6_m6  <= asr(s5_mq, 11) * cal.p6;
      s6_m3  <= cal.p3 * asr(s5_mq, 13);
      s6_mp5 <= s5_mp5;
      s6_mp2 <= s5_mp2;
      s6_t   <= s5_t;
      s6_pb  <= s5_pb;

      s7_bm  <= (asr(s6_b1, 10) + 32'd2097152) * cal.h2;
      s7_a   <= s6_a;
      s7_v2  <= asr(s6_m6 + (s6_mp5 << 1), 2) + (cal.p4 << 16);
      s7_v1b <= asr(asr(s6_m3, 3) + asr(s6_mp2, 1), 18);
      s7_t   <= s6_t;
      s7_pb  <= s6_pb;

      s8_b  <= asr(s7_bm + 32'd8192, 14);
      s8_a  <= s7_a;
      s8_pm <= (32'd32768 + s7_v1b) * cal.p1;
      s8_pn <= s7_pb - asr(s7_v2, 12);
      s8_t  <= s7_t;

      s9_hh   <= s8_a * s8_b;
      s9_den  <= asr(s8_pm, 15);
      s9_pnum <= s8_pn * 32'd3125;
      s9_t    <= s8_t;

      s10_hq2 <= hq * hq;
      s10_hh  <= s9_hh;
      s10_den <= s9_den;
      s10_dz  <= (s9_den == '0);
      s10_dbl <= s9_pnum[31];
      s10_dvd <= s9_pnum[31] ? s9_pnum : (s9_pnum << 1);
      s10_t   <= s9_t;

      s11_hm  <= asr(s10_hq2, 7) * cal.h1;
      s11_hh  <= s10_hh;
      s11_den <= s10_den;
      s11_dz  <= s10_dz;
      s11_dbl <= s10_dbl;
      s11_dvd <= s10_dvd;
      s11_t   <= s10_t;

      s12_den      <= s11_den;
      s12_dvd      <= s11_dvd;
      s12_side.t   <= s11_t;
      s12_side.h   <= hsat;
      s12_side.dz  <= s11_dz;
      s12_side.dbl <= s11_dbl;

      r1_p    <= dq_side.dz ? '0 : (dq_side.dbl ? (dq_q << 1) : dq_q);
      r1_side <= dq_side;

      r2_mpp  <= (r1_p >> 3) * (r1_p >> 3);
      r2_mp8  <= (r1_p >> 2) * cal.p8;
      r2_p    <= r1_p;
      r2_side <= r1_side;

      r3_mt   <= cal.p9 * (r2_mpp >> 13);
      r3_v2t  <= asr(r2_mp8, 13);
      r3_p    <= r2_p;
      r3_side <= r2_side;

      temperature_centi     <= r3_side.t;
      humidity_q10          <= r3_side.h;
      pressure_divisor_zero <= r3_side.dz;
      if (pf[33]) begin
        pressure_pa <= '0;
      end else if (pf > 34'd1048575) begin
        pressure_pa <= 20'hfffff;
      end else begin
        pressure_pa <= pf[19:0];
      end
    end
  end

  esrc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (v[12]),
    .dividend (s12_dvd),
    .divisor  (s12_den),
    .in_side  (s12_side),
    .out_v    (dq_v),
    .quotient (dq_q),
    .out_side (dq_side)
  );

endmodule

### src/env_sensor_raw_compensation.sv
`timescale 1ns / 1ps

// Compensates one raw temperature, pressure and humidity reading per word using the
// calibration registers, and accepts a new word every cycle while the output side keeps
// taking results. A word passes from input to output through one front register, the
// four-word queue, twelve arithmetic stages, 32 stages of the one-bit-per-stage pressure
// divider and four trim and output stages. The divider pipeline is the longest part of
// that path. Configuration is taken every cycle and must only change while idle.

module env_sensor_raw_compensation import esrc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        raw_temperature,
  input  logic [19:0]        raw_pressure,
  input  logic [15:0]        raw_humidity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] temperature_centi,
  output logic [16:0]        humidity_q10,
  output logic [19:0]        pressure_pa,
  output logic               pressure_divisor_zero,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [47:0] cal_temp;
  logic [63:0] cal_plo, cal_phi, cal_hum;
  logic [15:0] cal_p9;
  esrc_cal_t   cal;
  esrc_qstat_t qs;
  esrc_item_t  fitem, qitem;
  logic        push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp <= '0;
      cal_plo  <= '0;
      cal_phi  <= '0;
      cal_p9   <= '0;
      cal_hum  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMP:     cal_temp <= cfg_data[47:0];
        REG_PRES_LOW: cal_plo  <= cfg_data;
        REG_PRES_HI:  cal_phi  <= cfg_data;
        REG_PRES_P9:  cal_p9   <= cfg_data[15:0];
        REG_HUM:      cal_hum  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = {16'd0, cal_temp[15:0]};
    cal.t2 = sx16(cal_temp[31:16]);
    cal.t3 = sx16(cal_temp[47:32]);
    cal.p1 = {16'd0, cal_plo[15:0]};
    cal.p2 = sx16(cal_plo[31:16]);
    cal.p3 = sx16(cal_plo[47:32]);
    cal.p4 = sx16(cal_plo[63:48]);
    cal.p5 = sx16(cal_phi[15:0]);
    cal.p6 = sx16(cal_phi[31:16]);
    cal.p7 = sx16(cal_phi[47:32]);
    cal.p8 = sx16(cal_phi[63:48]);
    cal.p9 = sx16(cal_p9);
    cal.h1 = {24'd0, cal_hum[7:0]};
    cal.h2 = sx16(cal_hum[23:8]);
    cal.h3 = {24'd0, cal_hum[31:24]};
    cal.h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
    cal.h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
    cal.h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};
  end

  esrc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .raw_humidity    (raw_humidity),
    .cal             (cal),
    .qs              (qs),
    .push            (push),
    .item            (fitem)
  );

  esrc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (fitem),
    .pop   (pop),
    .rdata (qitem),
    .qs    (qs)
  );

  esrc_back u_back (
    .clk                   (clk),
    .rst                   (rst),
    .cal                   (cal),
    .qs                    (qs),
    .qitem                 (qitem),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .temperature_centi     (temperature_centi),
    .humidity_q10          (humidity_q10),
    .pressure_pa           (pressure_pa),
    .pressure_divisor_zero (pressure_divisor_zero)
  );

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> !qs.empty)
    else $error("queue popped while empty");
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qs.count <= QCW'(QDEPTH))
    else $error("queue count beyond depth");
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> humidity_q10 <= 17'd102400)
    else $error("humidity out of range");
`endif

endmodule
